>>> rtl/twm_pkg.sv
// Shared types, constants and the arctangent table for the twist merge and
// wheel kinematics block. No dependencies.
`default_nettype none

package twm_pkg;

  // CORDIC chain length, capped at the size of the arctangent table
  localparam int CORDIC_STAGES = 14;
  localparam int ATAN_ENTRIES  = 20;
  localparam int NCELLS = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  localparam int FRONT_STG = 3;
  localparam int TAIL_STG  = 4;
  localparam int NSTG      = FRONT_STG + NCELLS + TAIL_STG;

  localparam int XY_W = 33;   // Q22 vector components with CORDIC growth
  localparam int Z_W  = 23;   // Q20 angle accumulator
  localparam int SH_W = 5;

  localparam logic [14:0] WHEEL_LIMIT  = 15'd20480;
  localparam logic [13:0] ANGLE_LIMIT  = 14'd12868;
  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
  localparam logic [16:0] DEADBAND_LSB = 17'd20;

  // register indexes
  localparam logic [1:0] REG_MAX_LIN  = 2'd0;
  localparam logic [1:0] REG_MAX_TURN = 2'd1;
  localparam logic [1:0] REG_BODY_R   = 2'd2;
  localparam logic [1:0] REG_INV_R    = 2'd3;

  localparam logic [14:0] RST_MAX_LIN  = 15'd2048;
  localparam logic [14:0] RST_MAX_TURN = 15'd1430;
  localparam logic [14:0] RST_BODY_R   = 15'd410;
  localparam logic [15:0] RST_INV_R    = 16'd5120;

  typedef struct packed {
    logic [14:0] max_lin;
    logic [14:0] max_turn;
    logic [14:0] body_r;
    logic [15:0] inv_r;
  } cfg_t;

  // values that ride along the CORDIC chain
  typedef struct packed {
    logic signed [15:0] v;
    logic signed [15:0] w;
    logic [31:0]        lp_mag;   // |v*2048 + w*R|
    logic               lp_neg;
    logic [31:0]        rp_mag;   // |v*2048 - w*R|
    logic               rp_neg;
  } side_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    side_t                  side;
  } rot_t;

  function automatic logic signed [Z_W-1:0] atan_q20(input logic [SH_W-1:0] i);
    logic signed [Z_W-1:0] a;
    unique case (i)
      5'd0:    a = 23'sd823550;
      5'd1:    a = 23'sd486170;
      5'd2:    a = 23'sd256879;
      5'd3:    a = 23'sd130396;
      5'd4:    a = 23'sd65451;
      5'd5:    a = 23'sd32757;
      5'd6:    a = 23'sd16383;
      5'd7:    a = 23'sd8192;
      5'd8:    a = 23'sd4096;
      5'd9:    a = 23'sd2048;
      5'd10:   a = 23'sd1024;
      5'd11:   a = 23'sd512;
      5'd12:   a = 23'sd256;
      5'd13:   a = 23'sd128;
      5'd14:   a = 23'sd64;
      5'd15:   a = 23'sd32;
      5'd16:   a = 23'sd16;
      5'd17:   a = 23'sd8;
      5'd18:   a = 23'sd4;
      5'd19:   a = 23'sd2;
      default: a = 23'sd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

>>> rtl/twm_merge.sv
// Front end: merge and saturate the speed pairs, deadband, body radius
// product and CORDIC seed. Depends on twm_pkg.
`default_nettype none

module twm_merge import twm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 vld_i,
  input  logic signed [15:0]   planned_linear,
  input  logic signed [15:0]   planned_angular,
  input  logic signed [15:0]   learned_linear,
  input  logic signed [15:0]   learned_angular,
  input  logic [FRONT_STG-1:0] en,
  output logic [FRONT_STG-1:0] vld_o,
  output rot_t                 rot_o
);

  logic [FRONT_STG-1:0] vld_r;

  // stage 0: sums, saturation and deadband
  logic signed [16:0] vsum, wsum, vlim, wlim, vsat, wsat;
  logic [16:0]        vabs17;
  logic               dead;
  logic signed [15:0] v0_r, w0_r;

  always_comb begin
    vsum = {planned_linear[15], planned_linear} + {learned_linear[15], learned_linear};
    wsum = {planned_angular[15], planned_angular} + {learned_angular[15], learned_angular};
    vlim = $signed({2'b00, cfg.max_lin});
    wlim = $signed({2'b00, cfg.max_turn});
    if (vsum > vlim)       vsat = vlim;
    else if (vsum < -vlim) vsat = -vlim;
    else                   vsat = vsum;
    if (wsum > wlim)       wsat = wlim;
    else if (wsum < -wlim) wsat = -wlim;
    else                   wsat = wsum;
    vabs17 = vsat[16] ? 17'(-vsat) : 17'(vsat);
    dead   = (vabs17 <= DEADBAND_LSB);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      v0_r <= vsat[15:0];
      w0_r <= dead ? 16'sd0 : wsat[15:0];
    end
  end

  // stage 1: w * body radius, Q22
  logic signed [15:0] v1_r;
  logic signed [31:0] wr1_r;
  logic signed [15:0] w1_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      v1_r  <= v0_r;
      w1_r  <= w0_r;
      wr1_r <= 32'(w0_r) * 32'($signed({1'b0, cfg.body_r}));
    end
  end

  // stage 2: wheel sums as sign and magnitude, CORDIC seed
  logic signed [32:0] vq, wr33, sp, sm, sp_n, sm_n;
  logic [15:0]        vabs;
  logic signed [15:0] vneg;
  rot_t               rot_nxt, rot_r;

  always_comb begin
    vq   = {{6{v1_r[15]}}, v1_r, 11'b0};
    wr33 = {wr1_r[31], wr1_r};
    sp   = vq + wr33;
    sm   = vq - wr33;
    sp_n = -sp;
    sm_n = -sm;
    vneg = -v1_r;
    vabs = v1_r[15] ? vneg : v1_r;
    rot_nxt.x           = $signed({6'b0, vabs, 11'b0});
    rot_nxt.y           = -wr33;
    rot_nxt.z           = '0;
    rot_nxt.side.v      = v1_r;
    rot_nxt.side.w      = w1_r;
    rot_nxt.side.lp_neg = sp[32];
    rot_nxt.side.lp_mag = sp[32] ? sp_n[31:0] : sp[31:0];
    rot_nxt.side.rp_neg = sm[32];
    rot_nxt.side.rp_mag = sm[32] ? sm_n[31:0] : sm[31:0];
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      rot_r <= rot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= vld_i;
      end
      for (int k = 1; k < FRONT_STG; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign vld_o = vld_r;
  assign rot_o = rot_r;

endmodule

`default_nettype wire

>>> rtl/twm_cordic_cell.sv
// One vectoring CORDIC micro-rotation with its pipeline register; carries
// the side values along. Depends on twm_pkg.
`default_nettype none

module twm_cordic_cell import twm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_i,
  input  rot_t                  rot_i,
  input  logic [SH_W-1:0]       shift_i,
  input  logic signed [Z_W-1:0] atan_i,
  output logic                  vld_o,
  output rot_t                  rot_o
);

  logic signed [XY_W-1:0] xi, yi, dx, dy;
  logic signed [Z_W-1:0]  zi;
  rot_t                   rot_nxt, rot_r;
  logic                   vld_r;

  always_comb begin
    xi = rot_i.x;
    yi = rot_i.y;
    zi = rot_i.z;
    dx = yi >>> shift_i;   // floor shift
    dy = xi >>> shift_i;
    rot_nxt = rot_i;
    if (yi < 0) begin
      rot_nxt.x = xi - dx;
      rot_nxt.y = yi + dy;
      rot_nxt.z = zi - atan_i;
    end else begin
      rot_nxt.x = xi + dx;
      rot_nxt.y = yi - dy;
      rot_nxt.z = zi + atan_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r <= rot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  assign vld_o = vld_r;
  assign rot_o = rot_r;

endmodule

`default_nettype wire

>>> rtl/twm_scale.sv
// Back end: gain correction, radius scaling, rounding and limits for the
// wheel rates and steering angle. Depends on twm_pkg.
`default_nettype none

module twm_scale import twm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         inv_r,
  input  logic                vld_i,
  input  rot_t                rot_i,
  input  logic [TAIL_STG-1:0] en,
  output logic [TAIL_STG-1:0] vld_o,
  output logic signed [15:0]  linear_cmd,
  output logic signed [15:0]  angular_cmd,
  output logic signed [15:0]  left_wheel_rate,
  output logic signed [15:0]  right_wheel_rate,
  output logic signed [15:0]  drive_wheel_rate,
  output logic signed [14:0]  steer_angle
);

  typedef struct packed {
    logic signed [15:0] v;
    logic signed [15:0] w;
    logic signed [14:0] steer;
  } carry_t;

  logic [TAIL_STG-1:0] vld_r;

  // stage 0: three products and the angle
  logic signed [Z_W-1:0] zi, zn;
  logic [21:0]           zabs;
  logic [22:0]           zsum;
  logic [15:0]           zr;
  logic [13:0]           zc;
  logic                  sneg;
  carry_t                c0_nxt, c0_r;
  logic [46:0]           xg0_r;
  logic [47:0]           lp0_r, rp0_r;
  logic                  lneg0_r, rneg0_r;

  always_comb begin
    zi   = rot_i.z;
    zn   = -zi;
    zabs = zi[Z_W-1] ? zn[21:0] : zi[21:0];
    zsum = {1'b0, zabs} + 23'd64;
    zr   = zsum[22:7];
    zc   = (zr > {2'b00, ANGLE_LIMIT}) ? ANGLE_LIMIT : zr[13:0];
    sneg = zi[Z_W-1] ^ rot_i.side.v[15];
    c0_nxt.v = rot_i.side.v;
    c0_nxt.w = rot_i.side.w;
    if (rot_i.side.v == 16'sd0) c0_nxt.steer = 15'sd0;
    else if (sneg)              c0_nxt.steer = 15'd0 - {1'b0, zc};
    else                        c0_nxt.steer = {1'b0, zc};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      c0_r    <= c0_nxt;
      xg0_r   <= {16'b0, rot_i.x[30:0]} * {31'b0, INV_GAIN_Q16};
      lp0_r   <= {32'b0, inv_r} * {16'b0, rot_i.side.lp_mag};
      rp0_r   <= {32'b0, inv_r} * {16'b0, rot_i.side.rp_mag};
      lneg0_r <= rot_i.side.lp_neg;
      rneg0_r <= rot_i.side.rp_neg;
    end
  end

  // stage 1: magnitude rounding, left and right final values (negated)
  logic [46:0]        xg_rnd;
  logic [47:0]        lp_rnd, rp_rnd;
  logic [28:0]        lr, rr;
  logic [14:0]        lc, rc;
  logic signed [15:0] left_nxt, right_nxt;
  carry_t             c1_r;
  logic [30:0]        mag1_r;
  logic signed [15:0] left1_r, right1_r;

  always_comb begin
    xg_rnd = xg0_r + 47'd32768;
    lp_rnd = lp0_r + 48'd262144;
    rp_rnd = rp0_r + 48'd262144;
    lr     = lp_rnd[47:19];
    rr     = rp_rnd[47:19];
    lc     = (lr > {14'b0, WHEEL_LIMIT}) ? WHEEL_LIMIT : lr[14:0];
    rc     = (rr > {14'b0, WHEEL_LIMIT}) ? WHEEL_LIMIT : rr[14:0];
    // outputs carry the opposite sign of the wheel sums
    left_nxt  = lneg0_r ? {1'b0, lc} : 16'd0 - {1'b0, lc};
    right_nxt = rneg0_r ? {1'b0, rc} : 16'd0 - {1'b0, rc};
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      c1_r     <= c0_r;
      mag1_r   <= xg_rnd[46:16];
      left1_r  <= left_nxt;
      right1_r <= right_nxt;
    end
  end

  // stage 2: magnitude over wheel radius
  carry_t             c2_r;
  logic [46:0]        dp2_r;
  logic signed [15:0] left2_r, right2_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c2_r     <= c1_r;
      dp2_r    <= {31'b0, inv_r} * {16'b0, mag1_r};
      left2_r  <= left1_r;
      right2_r <= right1_r;
    end
  end

  // stage 3: drive rounding and limit, output register
  logic [46:0]        dp_rnd;
  logic [27:0]        dr;
  logic [14:0]        dc;
  logic signed [15:0] drive_nxt;

  always_comb begin
    dp_rnd = dp2_r + 47'd262144;
    dr     = dp_rnd[46:19];
    dc     = (dr > {13'b0, WHEEL_LIMIT}) ? WHEEL_LIMIT : dr[14:0];
    if (c2_r.v == 16'sd0) drive_nxt = 16'sd0;
    else if (c2_r.v[15])  drive_nxt = 16'd0 - {1'b0, dc};
    else                  drive_nxt = {1'b0, dc};
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      linear_cmd       <= c2_r.v;
      angular_cmd      <= c2_r.w;
      left_wheel_rate  <= left2_r;
      right_wheel_rate <= right2_r;
      drive_wheel_rate <= drive_nxt;
      steer_angle      <= c2_r.steer;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= vld_i;
      end
      for (int k = 1; k < TAIL_STG; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign vld_o = vld_r;

endmodule

`default_nettype wire

>>> rtl/twist_merge_wheel_kinematics_top.sv
// Top level: configuration registers, per-stage flow control, front end,
// CORDIC cell chain and back end. Depends on twm_pkg, twm_merge,
// twm_cordic_cell and twm_scale.
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------------------
//   in      | in_valid / in_ready   | planned/learned linear and angular, Q5.11
//   out     | out_valid / out_ready | commands, wheel rates Q5.11, steer Q2.13
//   cfg     | cfg_wr_en             | cfg_index, cfg_wdata
//
// One transfer per cycle in and out while out_ready is high; the pipeline depth
// is set by the front end, the CORDIC cell chain and the back end. Reset clears
// all stage valid bits and loads the register defaults. A stage holds while it
// and all later stages are full and out_ready is low; empty stages close up, so
// in_ready stays high while any stage is free, even with a result waiting.
`default_nettype none

module twist_merge_wheel_kinematics_top import twm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_planned_linear,
  input  logic signed [15:0] in_planned_angular,
  input  logic signed [15:0] in_learned_linear,
  input  logic signed [15:0] in_learned_angular,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_linear_cmd,
  output logic signed [15:0] out_angular_cmd,
  output logic signed [15:0] out_left_wheel_rate,
  output logic signed [15:0] out_right_wheel_rate,
  output logic signed [15:0] out_drive_wheel_rate,
  output logic signed [14:0] out_steer_angle,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  localparam int TAIL_BASE = FRONT_STG + NCELLS;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_lin  <= RST_MAX_LIN;
      cfg_r.max_turn <= RST_MAX_TURN;
      cfg_r.body_r   <= RST_BODY_R;
      cfg_r.inv_r    <= RST_INV_R;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MAX_LIN:  cfg_r.max_lin  <= cfg_wdata[14:0];
        REG_MAX_TURN: cfg_r.max_turn <= cfg_wdata[14:0];
        REG_BODY_R:   cfg_r.body_r   <= cfg_wdata[14:0];
        REG_INV_R:    cfg_r.inv_r    <= cfg_wdata;
      endcase
    end
  end

  logic [NSTG-1:0] vld, en;

  // a stage may load when it is empty or the stage after it loads;
  // flattens to an OR of out_ready and the inverted valid bits from it downstream
  always_comb begin
    en[NSTG-1] = ~vld[NSTG-1] | out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NSTG-1];

  rot_t rot_c [NCELLS+1];

  twm_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .vld_i           (in_valid),
    .planned_linear  (in_planned_linear),
    .planned_angular (in_planned_angular),
    .learned_linear  (in_learned_linear),
    .learned_angular (in_learned_angular),
    .en              (en[FRONT_STG-1:0]),
    .vld_o           (vld[FRONT_STG-1:0]),
    .rot_o           (rot_c[0])
  );

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    twm_cordic_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en[FRONT_STG+k]),
      .vld_i   (vld[FRONT_STG+k-1]),
      .rot_i   (rot_c[k]),
      .shift_i (SH_W'(k)),
      .atan_i  (atan_q20(SH_W'(k))),
      .vld_o   (vld[FRONT_STG+k]),
      .rot_o   (rot_c[k+1])
    );
  end

  twm_scale u_scale (
    .clk              (clk),
    .rst_n            (rst_n),
    .inv_r            (cfg_r.inv_r),
    .vld_i            (vld[TAIL_BASE-1]),
    .rot_i            (rot_c[NCELLS]),
    .en               (en[NSTG-1:TAIL_BASE]),
    .vld_o            (vld[NSTG-1:TAIL_BASE]),
    .linear_cmd       (out_linear_cmd),
    .angular_cmd      (out_angular_cmd),
    .left_wheel_rate  (out_left_wheel_rate),
    .right_wheel_rate (out_right_wheel_rate),
    .drive_wheel_rate (out_drive_wheel_rate),
    .steer_angle      (out_steer_angle)
  );

  a_steer_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_steer_angle <= 15'sd12868 && out_steer_angle >= -15'sd12868))
    else $error("steer angle beyond limit");

  a_wheel_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_left_wheel_rate <= 16'sd20480 && out_left_wheel_rate >= -16'sd20480
                && out_right_wheel_rate <= 16'sd20480 && out_right_wheel_rate >= -16'sd20480
                && out_drive_wheel_rate <= 16'sd20480 && out_drive_wheel_rate >= -16'sd20480))
    else $error("wheel rate beyond limit");

  a_deadband: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_linear_cmd <= 16'sd20 && out_linear_cmd >= -16'sd20)
      |-> out_angular_cmd == 16'sd0)
    else $error("angular command inside linear deadband");

  a_zero_linear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_linear_cmd == 16'sd0)
      |-> (out_drive_wheel_rate == 16'sd0 && out_steer_angle == 15'sd0
           && out_left_wheel_rate == 16'sd0 && out_right_wheel_rate == 16'sd0))
    else $error("motion output with zero linear speed");

endmodule

`default_nettype wire

>>> verif/twist_merge_wheel_kinematics_top_tb.sv
// Testbench for twist_merge_wheel_kinematics_top: random and directed twist commands,
// with a scoreboard that predicts the merged commands, wheel rates and steer angle.
// Depends on twm_pkg and the top level RTL.
`timescale 1ns / 100ps

module twist_merge_wheel_kinematics_top_tb;
  import twm_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int NUM_PHASES = 6;
  localparam int DRAIN_CYCLES = 30;

  localparam longint ARCTAN_Q20 [20] = '{
    823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
    1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
  };

  typedef struct packed {
    logic signed [15:0] planned_linear;
    logic signed [15:0] planned_angular;
    logic signed [15:0] learned_linear;
    logic signed [15:0] learned_angular;
  } twist_cmd_t;

  typedef struct packed {
    logic signed [15:0] linear_cmd;
    logic signed [15:0] angular_cmd;
    logic signed [15:0] left_rate;
    logic signed [15:0] right_rate;
    logic signed [15:0] drive_rate;
    logic signed [14:0] steer;
  } wheel_result_t;

  class wheel_scoreboard;
    logic [14:0]   max_lin;
    logic [14:0]   max_turn;
    logic [14:0]   body_r;
    logic [15:0]   inv_r;
    wheel_result_t pending_q[$];
    int            mismatches;

    function new();
      max_lin    = RST_MAX_LIN;
      max_turn   = RST_MAX_TURN;
      body_r     = RST_BODY_R;
      inv_r      = RST_INV_R;
      mismatches = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_MAX_LIN:  max_lin  = data[14:0];
        REG_MAX_TURN: max_turn = data[14:0];
        REG_BODY_R:   body_r   = data[14:0];
        REG_INV_R:    inv_r    = data;
        default: ;
      endcase
    endfunction

    // nearest, ties away from zero
    function longint round_shift(longint x, int s);
      longint m;
      m = (x < 0) ? -x : x;
      m = (m + (longint'(1) << (s - 1))) >>> s;
      return (x < 0) ? -m : m;
    endfunction

    function longint clip(longint x, longint lim);
      if (x > lim) return lim;
      if (x < -lim) return -lim;
      return x;
    endfunction

    function wheel_result_t kinematics(twist_cmd_t c);
      wheel_result_t r;
      longint inv, v, w, av, wr, vq, x, y, z, dx, dy, left, right, drive, steer, mag;
      inv = longint'(inv_r);
      v = clip(longint'(c.planned_linear) + longint'(c.learned_linear), longint'(max_lin));
      w = clip(longint'(c.planned_angular) + longint'(c.learned_angular),
               longint'(max_turn));
      av = (v < 0) ? -v : v;
      if (av * 100 < 2048) w = 0;
      wr = w * longint'(body_r);   // Q22
      vq = v * 2048;
      left  = clip(round_shift(inv * (vq + wr), 19), longint'(WHEEL_LIMIT));
      right = clip(round_shift(inv * (vq - wr), 19), longint'(WHEEL_LIMIT));
      // vectoring: drive y to zero, z collects the angle in Q20
      x = av * 2048;
      y = -wr;
      z = 0;
      for (int i = 0; i < NCELLS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y < 0) begin
          x = x - dx; y = y + dy; z = z - ARCTAN_Q20[i];
        end else begin
          x = x + dx; y = y - dy; z = z + ARCTAN_Q20[i];
        end
      end
      if (v == 0) begin
        drive = 0;
        steer = 0;
      end else begin
        mag = round_shift(x * longint'(INV_GAIN_Q16), 16);
        drive = clip(round_shift(inv * mag, 19), longint'(WHEEL_LIMIT));
        steer = round_shift(z, 7);
        if (v < 0) begin
          drive = -drive;
          steer = -steer;
        end
        steer = clip(steer, longint'(ANGLE_LIMIT));
      end
      left  = -left;
      right = -right;
      r.linear_cmd  = v[15:0];
      r.angular_cmd = w[15:0];
      r.left_rate   = left[15:0];
      r.right_rate  = right[15:0];
      r.drive_rate  = drive[15:0];
      r.steer       = steer[14:0];
      return r;
    endfunction

    function void note_command(twist_cmd_t c);
      pending_q.push_back(kinematics(c));
    endfunction

    function void check_result(wheel_result_t got);
      wheel_result_t exp_r;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: lin %0d ang %0d", $realtime,
                   got.linear_cmd, got.angular_cmd);
        return;
      end
      exp_r = pending_q.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: mismatch exp lin %0d ang %0d left %0d right %0d drive %0d ",
                    "steer %0d | got lin %0d ang %0d left %0d right %0d drive %0d steer %0d"},
                   $realtime, exp_r.linear_cmd, exp_r.angular_cmd, exp_r.left_rate,
                   exp_r.right_rate, exp_r.drive_rate, exp_r.steer, got.linear_cmd,
                   got.angular_cmd, got.left_rate, got.right_rate, got.drive_rate,
                   got.steer);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_planned_linear;
  logic signed [15:0] in_planned_angular;
  logic signed [15:0] in_learned_linear;
  logic signed [15:0] in_learned_angular;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_linear_cmd;
  logic signed [15:0] out_angular_cmd;
  logic signed [15:0] out_left_wheel_rate;
  logic signed [15:0] out_right_wheel_rate;
  logic signed [15:0] out_drive_wheel_rate;
  logic signed [14:0] out_steer_angle;
  logic               cfg_wr_en;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_wdata;

  wheel_scoreboard sb;
  int              send_idle_pct;
  int              recv_idle_pct;
  int              quiet_cycles;

  twist_merge_wheel_kinematics_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_planned_linear    (in_planned_linear),
    .in_planned_angular   (in_planned_angular),
    .in_learned_linear    (in_learned_linear),
    .in_learned_angular   (in_learned_angular),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_linear_cmd       (out_linear_cmd),
    .out_angular_cmd      (out_angular_cmd),
    .out_left_wheel_rate  (out_left_wheel_rate),
    .out_right_wheel_rate (out_right_wheel_rate),
    .out_drive_wheel_rate (out_drive_wheel_rate),
    .out_steer_angle      (out_steer_angle),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: random backpressure, check on each transfer
  always @(posedge clk) begin
    if (out_valid && out_ready)
      sb.check_result({out_linear_cmd, out_angular_cmd, out_left_wheel_rate,
                       out_right_wheel_rate, out_drive_wheel_rate, out_steer_angle});
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic twist_cmd_t mk_cmd(logic [15:0] pl, pa, ll, la);
    return {pl, pa, ll, la};
  endfunction

  // uniform in [-span, span], span clamped to 1..32767
  function automatic logic [15:0] spread(int span);
    int s;
    s = (span > 32767) ? 32767 : ((span < 1) ? 1 : span);
    return 16'(int'($urandom_range(2 * s)) - s);
  endfunction

  function automatic twist_cmd_t random_command();
    twist_cmd_t c;
    int         kind;
    int         lin_span;
    int         turn_span;
    logic [15:0] t;
    kind      = $urandom_range(9);
    lin_span  = (int'(sb.max_lin) < 64) ? 64 : int'(sb.max_lin) + int'(sb.max_lin) / 8;
    turn_span = (int'(sb.max_turn) < 64) ? 64 : int'(sb.max_turn) + int'(sb.max_turn) / 8;
    c = mk_cmd(spread(lin_span), spread(turn_span), spread(lin_span / 4),
               spread(turn_span / 4));
    case (kind)
      0, 1: c = {$urandom(), $urandom()};
      8: begin
        c.planned_linear = spread(30);   // around the deadband edge
        c.learned_linear = spread(4);
      end
      9: begin
        t = 16'($urandom());             // linear cancels out exactly
        c.planned_linear = t;
        c.learned_linear = -t;
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic push_command(input twist_cmd_t c);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_planned_linear  <= c.planned_linear;
    in_planned_angular <= c.planned_angular;
    in_learned_linear  <= c.learned_linear;
    in_learned_angular <= c.learned_angular;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_command(c);
  endtask

  task automatic apply_settings(input logic [15:0] lin, turn, body, inv);
    logic [1:0]  idx [4];
    logic [15:0] val [4];
    idx = '{REG_MAX_LIN, REG_MAX_TURN, REG_BODY_R, REG_INV_R};
    val = '{lin, turn, body, inv};
    foreach (idx[k]) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[k];
      cfg_wdata <= val[k];
      @(posedge clk);
      sb.set_register(idx[k], val[k]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    twist_cmd_t directed [$];
    sb = new();
    send_idle_pct      = 0;
    recv_idle_pct      = 0;
    quiet_cycles       = 0;
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    out_ready          <= 1'b0;
    in_planned_linear  <= '0;
    in_planned_angular <= '0;
    in_learned_linear  <= '0;
    in_learned_angular <= '0;
    cfg_wr_en          <= 1'b0;
    cfg_index          <= REG_MAX_LIN;
    cfg_wdata          <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed = '{
      mk_cmd(16'h0000, 16'h0000, 16'h0000, 16'h0000),
      mk_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF),
      mk_cmd(16'h8000, 16'h8000, 16'h8000, 16'h8000),
      mk_cmd(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF),   // linear sums to -1
      mk_cmd(16'd20, 16'd500, 16'd0, 16'd0),            // just inside the deadband
      mk_cmd(16'd21, 16'd500, 16'd0, 16'd0),            // just outside it
      mk_cmd(-16'sd20, -16'sd500, 16'd0, 16'd0),
      mk_cmd(-16'sd21, -16'sd500, 16'd0, 16'd0),
      mk_cmd(16'd0, 16'd1000, 16'd0, 16'd0),            // no linear speed
      mk_cmd(16'd1024, 16'd1000, 16'd0, 16'd430),
      mk_cmd(-16'sd1024, -16'sd700, 16'd0, 16'd0),
      mk_cmd(16'd30, 16'd1430, 16'd0, 16'd0),           // steer near the angle limit
      mk_cmd(-16'sd30, -16'sd1430, 16'd0, 16'd0),
      mk_cmd(16'd2048, 16'd0, 16'd0, 16'd0),
      mk_cmd(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555)
    };

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0, 1: begin
          send_idle_pct = 32;
          recv_idle_pct = 81;
        end
        2, 3: begin
          send_idle_pct = 81;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (p)
        1: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);   // top bit dropped but for inv_r
        2: apply_settings(16'd0, 16'd0, 16'd0, 16'd1);
        3: apply_settings(16'($urandom_range(4096)), 16'($urandom_range(2048)),
                          16'($urandom_range(1024)), 16'd0);       // zero inverse radius
        4: apply_settings(16'($urandom()), 16'($urandom()), 16'($urandom()),
                          16'($urandom()));
        5: apply_settings(16'($urandom_range(1024, 8192)), 16'($urandom_range(512, 4096)),
                          16'($urandom_range(100, 2000)), 16'($urandom_range(1, 12000)));
        default: ;
      endcase
      if (p == 0)
        foreach (directed[k]) push_command(directed[k]);
      repeat (ITEMS_PER_PHASE) push_command(random_command());
      in_valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

>>> filelist.f
rtl/twm_pkg.sv
rtl/twm_merge.sv
rtl/twm_cordic_cell.sv
rtl/twm_scale.sv
rtl/twist_merge_wheel_kinematics_top.sv
verif/twist_merge_wheel_kinematics_top_tb.sv
